// File: hw/rtl/dvst_pkg.sv
// ----------------------------------------------------------------------------
// dvst_pkg
// shared types and constants of the distinct value set table
// ----------------------------------------------------------------------------
`default_nettype none

package dvst_pkg;

	localparam int SLOTS_DEF = 16;
	localparam int VALUE_W   = 32;
	localparam int ACTION_W  = 2;
	localparam int COUNT_W   = 5;
	localparam int COUNT_MAX = 31;

	typedef logic [ACTION_W-1:0]       action_t;
	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [COUNT_W-1:0]        count_t;

	// action codes
	localparam action_t ACT_ADD    = 2'd0;
	localparam action_t ACT_REMOVE = 2'd1;
	localparam action_t ACT_SEARCH = 2'd2;

	// scan token handed from cell to cell
	typedef struct packed {
		logic active;
		logic hit;
		logic free_seen;
	} tok_t;

	// update broadcast to all cells at the end of a scan
	typedef struct packed {
		logic add_en;
		logic remove_en;
	} commit_t;

endpackage

`default_nettype wire

// File: hw/rtl/dvst_req_if.sv
// ----------------------------------------------------------------------------
// dvst_req_if
// request channel: action and value, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface dvst_req_if;
	logic              valid;
	logic              ready;
	dvst_pkg::action_t action;
	dvst_pkg::value_t  element_value;

	modport source (output valid, output action, output element_value, input ready);
	modport sink   (input valid, input action, input element_value, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dvst_rsp_if.sv
// ----------------------------------------------------------------------------
// dvst_rsp_if
// response channel: result flags and count, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface dvst_rsp_if;
	logic             valid;
	logic             ready;
	logic             success;
	logic             full_refused;
	dvst_pkg::count_t element_count;
	logic             set_empty;

	modport source (output valid, output success, output full_refused,
		output element_count, output set_empty, input ready);
	modport sink   (input valid, input success, input full_refused,
		input element_count, input set_empty, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dvst_cell.sv
// ----------------------------------------------------------------------------
// dvst_cell
// one table slot: stored value, valid mark, compare and token hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module dvst_cell (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire dvst_pkg::value_t value,
	input  wire dvst_pkg::tok_t   tok_in,
	input  wire dvst_pkg::commit_t commit,
	output dvst_pkg::tok_t        tok_out
);
	import dvst_pkg::*;

	value_t entry_q;
	logic   valid_q;
	logic   sel_hit_q;
	logic   sel_free_q;
	tok_t   tok_q;
	logic   match;

	assign match   = valid_q && (entry_q == value);
	assign tok_out = tok_q;

	// slot payload, written only on an add that picked this slot
	always_ff @(posedge clk) begin
		if (commit.add_en && sel_free_q) begin
			entry_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			sel_hit_q  <= 1'b0;
			sel_free_q <= 1'b0;
			tok_q      <= '0;
		end else begin
			tok_q.active <= tok_in.active;
			if (tok_in.active) begin
				sel_hit_q       <= match;
				sel_free_q      <= !valid_q && !tok_in.free_seen;
				tok_q.hit       <= tok_in.hit || match;
				tok_q.free_seen <= tok_in.free_seen || !valid_q;
			end
			if (commit.add_en && sel_free_q) begin
				valid_q <= 1'b1;
			end else if (commit.remove_en && sel_hit_q) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/distinct_value_set_table_core.sv
// ----------------------------------------------------------------------------
// distinct_value_set_table_core
// set of distinct 32-bit values kept in a row of SLOTS table cells
// ----------------------------------------------------------------------------
// Each request (add, remove or search of one value) is taken when the block
// is idle and sends a scan token down the row of cells, one cell per cycle.
// Every cell compares its entry with the request value and notes whether it
// holds the value or is the lowest free slot; the token collects both facts.
// When the token leaves the last cell its result is registered and, once the
// output register is free, the update is broadcast to the cells and one
// response transaction is loaded into the output register. A new request is
// accepted only after that, once the block is back in idle, and also while
// the previous response still waits in the output register. After reset the
// table is empty and ready at once. element_count saturates at 31 for tables
// larger than 31 slots; set_empty always reflects the true count.
// ----------------------------------------------------------------------------
`default_nettype none

module distinct_value_set_table_core #(
	parameter int SLOTS = dvst_pkg::SLOTS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	dvst_req_if.sink   req,
	dvst_rsp_if.source rsp
);
	import dvst_pkg::*;

	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]       state_q;
	logic             start_q;
	action_t          action_q;
	value_t           value_q;
	tok_t             fin_q;
	logic [CNT_W-1:0] count_q;

	// output register
	logic   rsp_valid_q;
	logic   success_q;
	logic   refused_q;
	count_t count_out_q;
	logic   empty_q;

	tok_t    tok [SLOTS+1];
	commit_t commit;

	logic             req_take;
	logic             out_free;
	logic             finish;
	logic             add_ok;
	logic             add_full;
	logic             rem_ok;
	logic             ok;
	logic [CNT_W-1:0] next_count;
	logic [EXT_W-1:0] count_ext;

	assign req.ready = (state_q == ST_IDLE);
	assign req_take  = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign finish    = (state_q == ST_DONE) && out_free;

	// outcome of the finished scan
	assign add_ok   = (action_q == ACT_ADD) && !fin_q.hit && fin_q.free_seen;
	assign add_full = (action_q == ACT_ADD) && !fin_q.hit && !fin_q.free_seen;
	assign rem_ok   = (action_q == ACT_REMOVE) && fin_q.hit;

	always_comb begin
		case (action_q)
			ACT_ADD:    ok = add_ok;
			ACT_REMOVE: ok = rem_ok;
			ACT_SEARCH: ok = fin_q.hit;
			default:    ok = 1'b0;
		endcase
	end

	always_comb begin
		next_count = count_q;
		if (add_ok) begin
			next_count = count_q + CNT_W'(1);
		end else if (rem_ok) begin
			next_count = count_q - CNT_W'(1);
		end
	end

	assign count_ext = EXT_W'(next_count);

	assign commit.add_en    = finish && add_ok;
	assign commit.remove_en = finish && rem_ok;

	// row of cells, token enters at the head in the cycle after acceptance
	assign tok[0] = '{active: start_q, hit: 1'b0, free_seen: 1'b0};

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		dvst_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.value   (value_q),
			.tok_in  (tok[i]),
			.commit  (commit),
			.tok_out (tok[i+1])
		);
	end

	// request hold registers
	always_ff @(posedge clk) begin
		if (req_take) begin
			action_q <= req.action;
			value_q  <= req.element_value;
		end
		if (tok[SLOTS].active) begin
			fin_q <= tok[SLOTS];
		end
	end

	// sequencer and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
			count_q <= '0;
		end else begin
			start_q <= req_take;
			case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (tok[SLOTS].active) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						count_q <= next_count;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// response output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			success_q   <= ok;
			refused_q   <= add_full;
			empty_q     <= (next_count == '0);
			count_out_q <= (count_ext > EXT_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
				: count_ext[COUNT_W-1:0];
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.success       = success_q;
	assign rsp.full_refused  = refused_q;
	assign rsp.element_count = count_out_q;
	assign rsp.set_empty     = empty_q;

endmodule

`default_nettype wire

// File: hw/rtl/dvst_checker.sv
// ----------------------------------------------------------------------------
// dvst_checker
// port-level checks of the distinct value set table
// ----------------------------------------------------------------------------
`default_nettype none

module dvst_checker #(
	parameter int SLOTS = dvst_pkg::SLOTS_DEF
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             rsp_valid,
	input wire logic             rsp_ready,
	input wire logic             success,
	input wire logic             full_refused,
	input wire dvst_pkg::count_t element_count,
	input wire logic             set_empty
);
	import dvst_pkg::*;

	localparam int FULL_SHOWN = (SLOTS > COUNT_MAX) ? COUNT_MAX : SLOTS;

	// empty flag agrees with the count
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (set_empty == (element_count == '0)))
		else $error("set_empty disagrees with element_count");

	// a refused add never reports success
	a_refused_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(success && full_refused))
		else $error("success and full_refused both set");

	// refusal only happens with every slot held
	a_refused_full: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && full_refused) |-> (element_count == COUNT_W'(FULL_SHOWN)))
		else $error("full_refused with free slots");

	// a stalled response stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid)
		else $error("response dropped while stalled");

endmodule

bind distinct_value_set_table_core dvst_checker #(.SLOTS(SLOTS)) u_dvst_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.success       (rsp.success),
	.full_refused  (rsp.full_refused),
	.element_count (rsp.element_count),
	.set_empty     (rsp.set_empty)
);

`default_nettype wire
